[src/cpu8se_pkg.sv]
// ----------------------------------------------------------------------------
// cpu8se_pkg
// Shared types and constants for the 8-bit instruction subset execute core:
// opcode values, the decoded instruction classes and the queue entry format.
// ----------------------------------------------------------------------------
package cpu8se_pkg;

  // Flag bit positions inside the 4-bit flag word
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Base of the high page used by LDH and LD (C),A
  localparam logic [15:0] HighPage = 16'hff00;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Primary opcodes handled by the decoder
  localparam logic [7:0] OpLdBImm   = 8'h06;
  localparam logic [7:0] OpLdCImm   = 8'h0E;
  localparam logic [7:0] OpLdDImm   = 8'h16;
  localparam logic [7:0] OpLdEImm   = 8'h1E;
  localparam logic [7:0] OpLdHImm   = 8'h26;
  localparam logic [7:0] OpLdLImm   = 8'h2E;
  localparam logic [7:0] OpLdAImm   = 8'h3E;
  localparam logic [7:0] OpJrNz     = 8'h20;
  localparam logic [7:0] OpJrZ      = 8'h28;
  localparam logic [7:0] OpJrNc     = 8'h30;
  localparam logic [7:0] OpJrC      = 8'h38;
  localparam logic [7:0] OpLdBcImm  = 8'h01;
  localparam logic [7:0] OpLdDeImm  = 8'h11;
  localparam logic [7:0] OpLdHlImm  = 8'h21;
  localparam logic [7:0] OpLdSpImm  = 8'h31;
  localparam logic [7:0] OpLddHlA   = 8'h32;
  localparam logic [7:0] OpLdHlA    = 8'h77;
  localparam logic [7:0] OpLdADe    = 8'h1A;
  localparam logic [7:0] OpLdCA     = 8'h4F;
  localparam logic [7:0] OpDecB     = 8'h05;
  localparam logic [7:0] OpIncC     = 8'h0C;
  localparam logic [7:0] OpDecBc    = 8'h0B;
  localparam logic [7:0] OpDecDe    = 8'h1B;
  localparam logic [7:0] OpDecHl    = 8'h2B;
  localparam logic [7:0] OpDecSp    = 8'h3B;
  localparam logic [7:0] OpPushBc   = 8'hC5;
  localparam logic [7:0] OpCall     = 8'hCD;
  localparam logic [7:0] OpXorB     = 8'hA8;
  localparam logic [7:0] OpXorC     = 8'hA9;
  localparam logic [7:0] OpXorD     = 8'hAA;
  localparam logic [7:0] OpXorE     = 8'hAB;
  localparam logic [7:0] OpXorH     = 8'hAC;
  localparam logic [7:0] OpXorL     = 8'hAD;
  localparam logic [7:0] OpXorA     = 8'hAF;
  localparam logic [7:0] OpPrefixCb = 8'hCB;
  localparam logic [7:0] OpLdhImmA  = 8'hE0;
  localparam logic [7:0] OpLdhCA    = 8'hE2;

  // 8-bit operand codes
  localparam logic [2:0] RegB  = 3'd0;
  localparam logic [2:0] RegC  = 3'd1;
  localparam logic [2:0] RegD  = 3'd2;
  localparam logic [2:0] RegE  = 3'd3;
  localparam logic [2:0] RegH  = 3'd4;
  localparam logic [2:0] RegL  = 3'd5;
  localparam logic [2:0] RegHl = 3'd6;
  localparam logic [2:0] RegA  = 3'd7;

  // 16-bit pair codes
  localparam logic [1:0] PairBc = 2'd0;
  localparam logic [1:0] PairDe = 2'd1;
  localparam logic [1:0] PairHl = 2'd2;

  // Instruction classes produced by the front
  typedef enum logic [4:0] {
    K_LD_R_IMM,
    K_LD_A_IMM,
    K_JR,
    K_LD_RR_IMM,
    K_LD_SP_IMM,
    K_LDD_HL_A,
    K_LD_HL_A,
    K_LD_A_DE,
    K_LD_C_A,
    K_DEC_B,
    K_INC_C,
    K_DEC_RR,
    K_DEC_SP,
    K_PUSH_BC,
    K_CALL,
    K_XOR,
    K_BIT,
    K_LDH_IMM,
    K_LDH_C,
    K_BAD
  } kind_t;

  // One classified instruction, as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  reg_sel;
    logic [1:0]  pair_sel;
    logic [2:0]  bit_sel;
    logic        cond_carry;
    logic        cond_want;
    logic [1:0]  len;
    logic [15:0] imm;
    logic [7:0]  read_data;
  } item_t;

endpackage

[src/cpu8se_front.sv]
// ----------------------------------------------------------------------------
// cpu8se_front
// Input side: takes instruction beats, classifies the opcode and pushes the
// decoded entry into the queue. Stalls the input while the queue is full.
// ----------------------------------------------------------------------------
module cpu8se_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          opcode,
  input  logic [7:0]          cb_opcode,
  input  logic [15:0]         imm,
  input  logic [7:0]          read_data,
  input  logic                q_full,
  output logic                q_push,
  output cpu8se_pkg::item_t   q_item
);

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the opcode
  always_comb begin
    q_item            = '0;
    q_item.kind       = cpu8se_pkg::K_BAD;
    q_item.imm        = imm;
    q_item.read_data  = read_data;
    q_item.len        = 2'd1;
    q_item.reg_sel    = opcode[5:3];
    q_item.pair_sel   = opcode[5:4];
    q_item.bit_sel    = cb_opcode[5:3];
    q_item.cond_carry = opcode[4];
    q_item.cond_want  = opcode[3];
    unique case (opcode) inside
      cpu8se_pkg::OpLdBImm, cpu8se_pkg::OpLdCImm, cpu8se_pkg::OpLdDImm,
      cpu8se_pkg::OpLdEImm, cpu8se_pkg::OpLdHImm, cpu8se_pkg::OpLdLImm: begin
        q_item.kind = cpu8se_pkg::K_LD_R_IMM;
        q_item.len  = 2'd2;
      end
      cpu8se_pkg::OpLdAImm: begin
        q_item.kind = cpu8se_pkg::K_LD_A_IMM;
        q_item.len  = 2'd2;
      end
      cpu8se_pkg::OpJrNz, cpu8se_pkg::OpJrZ, cpu8se_pkg::OpJrNc,
      cpu8se_pkg::OpJrC: begin
        q_item.kind = cpu8se_pkg::K_JR;
        q_item.len  = 2'd2;
      end
      cpu8se_pkg::OpLdBcImm, cpu8se_pkg::OpLdDeImm, cpu8se_pkg::OpLdHlImm: begin
        q_item.kind = cpu8se_pkg::K_LD_RR_IMM;
        q_item.len  = 2'd3;
      end
      cpu8se_pkg::OpLdSpImm: begin
        q_item.kind = cpu8se_pkg::K_LD_SP_IMM;
        q_item.len  = 2'd3;
      end
      cpu8se_pkg::OpLddHlA:  q_item.kind = cpu8se_pkg::K_LDD_HL_A;
      cpu8se_pkg::OpLdHlA:   q_item.kind = cpu8se_pkg::K_LD_HL_A;
      cpu8se_pkg::OpLdADe:   q_item.kind = cpu8se_pkg::K_LD_A_DE;
      cpu8se_pkg::OpLdCA:    q_item.kind = cpu8se_pkg::K_LD_C_A;
      cpu8se_pkg::OpDecB:    q_item.kind = cpu8se_pkg::K_DEC_B;
      cpu8se_pkg::OpIncC:    q_item.kind = cpu8se_pkg::K_INC_C;
      cpu8se_pkg::OpDecBc, cpu8se_pkg::OpDecDe, cpu8se_pkg::OpDecHl:
        q_item.kind = cpu8se_pkg::K_DEC_RR;
      cpu8se_pkg::OpDecSp:   q_item.kind = cpu8se_pkg::K_DEC_SP;
      cpu8se_pkg::OpPushBc:  q_item.kind = cpu8se_pkg::K_PUSH_BC;
      cpu8se_pkg::OpCall: begin
        q_item.kind = cpu8se_pkg::K_CALL;
        q_item.len  = 2'd3;
      end
      cpu8se_pkg::OpXorB, cpu8se_pkg::OpXorC, cpu8se_pkg::OpXorD,
      cpu8se_pkg::OpXorE, cpu8se_pkg::OpXorH, cpu8se_pkg::OpXorL,
      cpu8se_pkg::OpXorA: begin
        q_item.kind    = cpu8se_pkg::K_XOR;
        q_item.reg_sel = opcode[2:0];
      end
      cpu8se_pkg::OpPrefixCb: begin
        // Only BIT b,r is supported; (HL) operand is not
        q_item.len     = 2'd2;
        q_item.reg_sel = cb_opcode[2:0];
        if (cb_opcode[7:6] == 2'b01 && cb_opcode[2:0] != cpu8se_pkg::RegHl) begin
          q_item.kind = cpu8se_pkg::K_BIT;
        end
      end
      cpu8se_pkg::OpLdhImmA: begin
        q_item.kind = cpu8se_pkg::K_LDH_IMM;
        q_item.len  = 2'd2;
      end
      cpu8se_pkg::OpLdhCA:   q_item.kind = cpu8se_pkg::K_LDH_C;
      default:               q_item.kind = cpu8se_pkg::K_BAD;
    endcase
  end

endmodule

[src/cpu8se_queue.sv]
// ----------------------------------------------------------------------------
// cpu8se_queue
// Small register queue between the decode front and the execute back, so
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module cpu8se_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cpu8se_pkg::item_t   push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output cpu8se_pkg::item_t   head_item
);

  cpu8se_pkg::item_t                        entries [cpu8se_pkg::QueueDepth];
  logic [cpu8se_pkg::QueueIdxW-1:0]         wr_ptr;
  logic [cpu8se_pkg::QueueIdxW-1:0]         rd_ptr;
  logic [cpu8se_pkg::QueueCntW-1:0]         count;

  localparam logic [cpu8se_pkg::QueueCntW-1:0] CountFull =
    cpu8se_pkg::QueueCntW'(cpu8se_pkg::QueueDepth);
  localparam logic [cpu8se_pkg::QueueIdxW-1:0] LastIdx =
    cpu8se_pkg::QueueIdxW'(cpu8se_pkg::QueueDepth - 1);

  assign full       = (count == CountFull);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/cpu8se_back.sv]
// ----------------------------------------------------------------------------
// cpu8se_back
// Execute side: owns the architectural registers, runs the queue head
// instruction and drives the registered result beats. PUSH and CALL give a
// second beat carrying the low-byte write.
// ----------------------------------------------------------------------------
module cpu8se_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cpu8se_pkg::item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                write_en,
  output logic [15:0]         write_addr,
  output logic [7:0]          write_data,
  output logic                last,
  output logic [15:0]         pc_next,
  output logic [7:0]          acc,
  output logic [3:0]          flag_bits,
  output logic                bad_opcode
);

  // Architectural state
  logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
  logic [3:0]  flags;
  logic [15:0] sp;
  logic [15:0] pc;

  // Pending second write
  logic        second_pending;
  logic [15:0] second_addr;
  logic [7:0]  second_data;

  // Next-state values of one executed instruction
  logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
  logic [3:0]  flags_next;
  logic [15:0] sp_next;
  logic [15:0] pc_next_val;
  logic [1:0]  nwrites;
  logic [15:0] wa0, wa1;
  logic [7:0]  wd0, wd1;
  logic        bad;

  // Operand helpers
  logic [7:0]  r8_val;
  logic [15:0] pair_val;
  logic [15:0] pair_dec;
  logic [15:0] pc_seq;
  logic [15:0] jr_target;
  logic [15:0] ret_addr;
  logic [15:0] hl_val;
  logic [7:0]  alu_val;
  logic        cond_have;

  logic fire;
  logic exec;

  assign fire  = !out_valid || !out_stall;
  assign exec  = fire && !second_pending && q_valid;
  assign q_pop = exec;

  // Select the 8-bit operand
  always_comb begin
    case (q_item.reg_sel)
      cpu8se_pkg::RegB: r8_val = b_reg;
      cpu8se_pkg::RegC: r8_val = c_reg;
      cpu8se_pkg::RegD: r8_val = d_reg;
      cpu8se_pkg::RegE: r8_val = e_reg;
      cpu8se_pkg::RegH: r8_val = h_reg;
      cpu8se_pkg::RegL: r8_val = l_reg;
      cpu8se_pkg::RegA: r8_val = a_reg;
      default:          r8_val = 8'h00;
    endcase
  end

  // Select the 16-bit pair
  always_comb begin
    case (q_item.pair_sel)
      cpu8se_pkg::PairDe: pair_val = {d_reg, e_reg};
      cpu8se_pkg::PairHl: pair_val = {h_reg, l_reg};
      default:            pair_val = {b_reg, c_reg};
    endcase
  end

  assign hl_val    = {h_reg, l_reg};
  assign pair_dec  = pair_val - 16'd1;
  assign pc_seq    = pc + {14'd0, q_item.len};
  assign jr_target = pc + 16'd2 + {{8{q_item.imm[7]}}, q_item.imm[7:0]};
  assign ret_addr  = pc + 16'd3;
  assign cond_have = q_item.cond_carry ? flags[cpu8se_pkg::FlagC]
                                       : flags[cpu8se_pkg::FlagZ];

  // Execute the head instruction
  always_comb begin
    a_next      = a_reg;
    b_next      = b_reg;
    c_next      = c_reg;
    d_next      = d_reg;
    e_next      = e_reg;
    h_next      = h_reg;
    l_next      = l_reg;
    flags_next  = flags;
    sp_next     = sp;
    pc_next_val = pc_seq;
    nwrites     = 2'd0;
    wa0         = 16'h0000;
    wd0         = 8'h00;
    wa1         = 16'h0000;
    wd1         = 8'h00;
    bad         = 1'b0;
    alu_val     = 8'h00;
    unique case (q_item.kind)
      cpu8se_pkg::K_LD_R_IMM: begin
        case (q_item.reg_sel)
          cpu8se_pkg::RegB: b_next = q_item.imm[7:0];
          cpu8se_pkg::RegC: c_next = q_item.imm[7:0];
          cpu8se_pkg::RegD: d_next = q_item.imm[7:0];
          cpu8se_pkg::RegE: e_next = q_item.imm[7:0];
          cpu8se_pkg::RegH: h_next = q_item.imm[7:0];
          default:          l_next = q_item.imm[7:0];
        endcase
      end
      cpu8se_pkg::K_LD_A_IMM: a_next = q_item.imm[7:0];
      cpu8se_pkg::K_JR: begin
        if (cond_have == q_item.cond_want) begin
          pc_next_val = jr_target;
        end
      end
      cpu8se_pkg::K_LD_RR_IMM: begin
        case (q_item.pair_sel)
          cpu8se_pkg::PairDe: {d_next, e_next} = q_item.imm;
          cpu8se_pkg::PairHl: {h_next, l_next} = q_item.imm;
          default:            {b_next, c_next} = q_item.imm;
        endcase
      end
      cpu8se_pkg::K_LD_SP_IMM: sp_next = q_item.imm;
      cpu8se_pkg::K_LDD_HL_A: begin
        nwrites          = 2'd1;
        wa0              = hl_val;
        wd0              = a_reg;
        {h_next, l_next} = hl_val - 16'd1;
      end
      cpu8se_pkg::K_LD_HL_A: begin
        nwrites = 2'd1;
        wa0     = hl_val;
        wd0     = a_reg;
      end
      cpu8se_pkg::K_LD_A_DE: a_next = q_item.read_data;
      cpu8se_pkg::K_LD_C_A:  c_next = a_reg;
      cpu8se_pkg::K_DEC_B: begin
        alu_val    = b_reg - 8'd1;
        b_next     = alu_val;
        flags_next = {alu_val == 8'h00, 1'b1, b_reg[3:0] == 4'h0,
                      flags[cpu8se_pkg::FlagC]};
      end
      cpu8se_pkg::K_INC_C: begin
        alu_val    = c_reg + 8'd1;
        c_next     = alu_val;
        flags_next = {alu_val == 8'h00, 1'b0, c_reg[3:0] == 4'hf,
                      flags[cpu8se_pkg::FlagC]};
      end
      cpu8se_pkg::K_DEC_RR: begin
        case (q_item.pair_sel)
          cpu8se_pkg::PairDe: {d_next, e_next} = pair_dec;
          cpu8se_pkg::PairHl: {h_next, l_next} = pair_dec;
          default:            {b_next, c_next} = pair_dec;
        endcase
      end
      cpu8se_pkg::K_DEC_SP: sp_next = sp - 16'd1;
      cpu8se_pkg::K_PUSH_BC: begin
        nwrites = 2'd2;
        wa0     = sp - 16'd1;
        wd0     = b_reg;
        wa1     = sp - 16'd2;
        wd1     = c_reg;
        sp_next = sp - 16'd2;
      end
      cpu8se_pkg::K_CALL: begin
        nwrites     = 2'd2;
        wa0         = sp - 16'd1;
        wd0         = ret_addr[15:8];
        wa1         = sp - 16'd2;
        wd1         = ret_addr[7:0];
        sp_next     = sp - 16'd2;
        pc_next_val = q_item.imm;
      end
      cpu8se_pkg::K_XOR: begin
        alu_val    = a_reg ^ r8_val;
        a_next     = alu_val;
        flags_next = {alu_val == 8'h00, 3'b000};
      end
      cpu8se_pkg::K_BIT: begin
        flags_next = {~r8_val[q_item.bit_sel], 1'b0, 1'b1,
                      flags[cpu8se_pkg::FlagC]};
      end
      cpu8se_pkg::K_LDH_IMM: begin
        nwrites = 2'd1;
        wa0     = cpu8se_pkg::HighPage | {8'h00, q_item.imm[7:0]};
        wd0     = a_reg;
      end
      cpu8se_pkg::K_LDH_C: begin
        nwrites = 2'd1;
        wa0     = cpu8se_pkg::HighPage | {8'h00, c_reg};
        wd0     = a_reg;
      end
      default: bad = 1'b1;
    endcase
  end

  // Commit state on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= '0;
      b_reg <= '0;
      c_reg <= '0;
      d_reg <= '0;
      e_reg <= '0;
      h_reg <= '0;
      l_reg <= '0;
      flags <= '0;
      sp    <= '0;
      pc    <= '0;
    end else if (exec) begin
      a_reg <= a_next;
      b_reg <= b_next;
      c_reg <= c_next;
      d_reg <= d_next;
      e_reg <= e_next;
      h_reg <= h_next;
      l_reg <= l_next;
      flags <= flags_next;
      sp    <= sp_next;
      pc    <= pc_next_val;
    end
  end

  // Output control: first beat on execute, second beat from the pending slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (fire) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else begin
        out_valid      <= q_valid;
        second_pending <= q_valid && (nwrites == 2'd2);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      if (second_pending) begin
        write_en   <= 1'b1;
        write_addr <= second_addr;
        write_data <= second_data;
        last       <= 1'b1;
      end else if (q_valid) begin
        write_en    <= (nwrites != 2'd0);
        write_addr  <= wa0;
        write_data  <= wd0;
        last        <= (nwrites != 2'd2);
        pc_next     <= pc_next_val;
        acc         <= a_next;
        flag_bits   <= flags_next;
        bad_opcode  <= bad;
        second_addr <= wa1;
        second_data <= wd1;
      end
    end
  end

endmodule

[src/cpu8_subset_execute_core.sv]
// ----------------------------------------------------------------------------
// cpu8_subset_execute_core
// Executes one instruction of an 8-bit instruction subset per input beat and
// emits its memory writes and final register view as result beats.
// ----------------------------------------------------------------------------
// Path: an accepted input passes the queue, then the registered execute output,
//   before it appears as the first result beat.
// Throughput: 1 instruction per cycle while out_stall is low; PUSH BC and CALL
//   stall the next one as the single output register sends both write beats.
// Reset: synchronous; clears A, B-L, flags, SP, PC, the queue and output valid.
// ----------------------------------------------------------------------------
module cpu8_subset_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opcode,
  input  logic [7:0]  cb_opcode,
  input  logic [15:0] imm,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_en,
  output logic [15:0] write_addr,
  output logic [7:0]  write_data,
  output logic        last,
  output logic [15:0] pc_next,
  output logic [7:0]  acc,
  output logic [3:0]  flag_bits,
  output logic        bad_opcode
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  cpu8se_pkg::item_t push_item;
  cpu8se_pkg::item_t head_item;

  // Decode front
  cpu8se_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .cb_opcode (cb_opcode),
    .imm       (imm),
    .read_data (read_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decoupling queue
  cpu8se_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  // Execute back
  cpu8se_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .write_en   (write_en),
    .write_addr (write_addr),
    .write_data (write_data),
    .last       (last),
    .pc_next    (pc_next),
    .acc        (acc),
    .flag_bits  (flag_bits),
    .bad_opcode (bad_opcode)
  );

endmodule
